>>> sv/delimited_segment_extractor_defines.svh
// Assertion macros shared by the delimited segment extractor modules.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef DELIMITED_SEGMENT_EXTRACTOR_DEFINES_SVH
`define DELIMITED_SEGMENT_EXTRACTOR_DEFINES_SVH
`ifndef SYNTH
// Checked only outside reset.
`define DSE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("delimited segment extractor: assertion failed");
// Checked at every clock edge, reset included.
`define DSE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("delimited segment extractor: assertion failed");
`else
`define DSE_ASSERT(lbl, prop)
`define DSE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/dse_pkg.sv
// Types and constants of the delimited segment extractor.
// Used by every module of the block; depends on nothing.
`default_nettype none
package dse_pkg;

	localparam int CFG_W = 64;

	typedef logic [7:0][7:0] pattern_t;

	typedef enum logic [1:0] {
		CFG_START_LENGTH  = 2'd0,
		CFG_START_PATTERN = 2'd1,
		CFG_END_LENGTH    = 2'd2,
		CFG_END_PATTERN   = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		OUTCOME_OK       = 2'd0,
		OUTCOME_NO_START = 2'd1,
		OUTCOME_NO_END   = 2'd2,
		OUTCOME_ORDER    = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       stream_done;
		outcome_t   outcome;
	} res_t;

	typedef struct packed {
		logic start_ok;
		logic end_ok;
	} cell_flags_t;

endpackage
`default_nettype wire

>>> sv/dse_cell.sv
// One byte of the recent-byte window with its start and end token comparators.
// Depends on dse_pkg.
`default_nettype none
module dse_cell #(
	parameter int IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire logic              clear,
	input  wire logic [7:0]        byte_in,
	input  wire logic [3:0]        start_len,
	input  wire dse_pkg::pattern_t start_pat,
	input  wire logic [3:0]        end_len,
	input  wire dse_pkg::pattern_t end_pat,
	output logic [7:0]             byte_q,
	output dse_pkg::cell_flags_t   flags
);

	localparam logic [3:0] POS = 4'(IDX);

	logic [3:0] start_sel;
	logic [3:0] end_sel;

	assign start_sel = start_len - POS - 4'd1;
	assign end_sel   = end_len - POS - 4'd1;

	always_comb begin
		flags.start_ok = (POS >= start_len) || (byte_in == start_pat[start_sel[2:0]]);
		flags.end_ok   = (POS >= end_len) || (byte_in == end_pat[end_sel[2:0]]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= clear ? 8'd0 : byte_in;
		end
	end

endmodule
`default_nettype wire

>>> sv/dse_outbuf.sv
// Two-entry output buffer that separates the request side from result stalls.
// Depends on dse_pkg and delimited_segment_extractor_defines.svh.
`default_nettype none
`include "delimited_segment_extractor_defines.svh"
module dse_outbuf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire dse_pkg::res_t push_data,
	output logic               space,
	output logic               res_valid,
	input  wire logic          res_ready,
	output dse_pkg::res_t      res_data
);

	logic          main_valid_q;
	logic          skid_valid_q;
	dse_pkg::res_t main_q;
	dse_pkg::res_t skid_q;
	logic          pop;

	assign pop       = main_valid_q && res_ready;
	assign space     = !skid_valid_q;
	assign res_valid = main_valid_q;
	assign res_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_valid_q || pop) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_valid_q || pop) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	`DSE_ASSERT_ALWAYS(a_skid_behind_main, skid_valid_q |-> main_valid_q)
	`DSE_ASSERT(a_no_push_when_full, push |-> !skid_valid_q)
	`DSE_ASSERT(a_skid_drains, (skid_valid_q && pop) |=> (!skid_valid_q && main_valid_q))

endmodule
`default_nettype wire

>>> sv/delimited_segment_extractor.sv
// Channel   Signals                        Payload
// request   req_valid, req_ready, req_data dse_pkg::req_t (data_byte, last_byte)
// result    res_valid, res_ready, res_data dse_pkg::res_t (out_byte .. outcome)
// config    cfg_we, cfg_index, cfg_data    register write, no handshake
// One byte is taken per cycle while req_ready is high; the window compare in the cell
// row and the position add and compare settle in that single cycle. Any result enters the
// buffer at the accepting edge and is offered on the result side once in its main entry.
// Reset sets the start length register to 1 and clears the other registers, the window and all stream state.
// A stalled result side is absorbed by a two-entry buffer; req_ready falls only when both
// entries are held.
// Depends on dse_pkg, dse_cell, dse_outbuf and delimited_segment_extractor_defines.svh.
`default_nettype none
`include "delimited_segment_extractor_defines.svh"
module delimited_segment_extractor #(
	parameter int TOKEN_MAX      = 8,
	parameter int POSITION_WIDTH = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire dse_pkg::cfg_index_t       cfg_index,
	input  wire logic [dse_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire dse_pkg::req_t             req_data,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output dse_pkg::res_t                  res_data
);

	localparam int                    PW      = POSITION_WIDTH;
	localparam int                    TAPW    = $clog2(TOKEN_MAX + 1);
	localparam logic [3:0]            TOK_LEN = 4'(TOKEN_MAX);
	localparam logic [PW-1:0]         POS_MAX = '1;

	logic [3:0]        start_len_q;
	dse_pkg::pattern_t start_pat_q;
	logic [3:0]        end_len_q;
	dse_pkg::pattern_t end_pat_q;

	logic [PW-1:0] pos_q;
	logic [PW-1:0] seg_q;
	logic          start_q;
	logic          end_q;
	logic          err3_q;

	logic [3:0]           sl_eff;
	logic [3:0]           el_eff;
	logic [7:0]           tap [TOKEN_MAX+1];
	logic [7:0]           win_q [TOKEN_MAX];
	dse_pkg::cell_flags_t flags [TOKEN_MAX];
	logic                 start_all;
	logic                 end_all;
	logic                 accept;
	logic                 last;
	logic [PW-1:0]        pos_inc;
	logic                 start_hit;
	logic                 start_new;
	logic [PW-1:0]        seg_new;
	logic                 end_hit;
	logic                 end_new;
	logic [PW-1:0]        end_pos;
	logic                 err3_new;
	logic [PW-1:0]        gap;
	logic                 emit;
	dse_pkg::outcome_t    oc;
	dse_pkg::res_t        result;
	logic                 push;
	logic                 space;

	assign accept    = req_valid && req_ready;
	assign req_ready = space;
	assign last      = req_data.last_byte;

	always_comb begin
		sl_eff = start_len_q;
		if (start_len_q == 4'd0) begin
			sl_eff = 4'd1;
		end else if (start_len_q > TOK_LEN) begin
			sl_eff = TOK_LEN;
		end
		el_eff = (end_len_q > TOK_LEN) ? TOK_LEN : end_len_q;
	end

	assign tap[0] = req_data.data_byte;

	for (genvar k = 0; k < TOKEN_MAX; k++) begin : g_cell
		assign tap[k+1] = win_q[k];
		dse_cell #(
			.IDX(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (accept),
			.clear    (last),
			.byte_in  (tap[k]),
			.start_len(sl_eff),
			.start_pat(start_pat_q),
			.end_len  (el_eff),
			.end_pat  (end_pat_q),
			.byte_q   (win_q[k]),
			.flags    (flags[k])
		);
	end

	always_comb begin
		start_all = 1'b1;
		end_all   = 1'b1;
		for (int k = 0; k < TOKEN_MAX; k++) begin
			start_all = start_all & flags[k].start_ok;
			end_all   = end_all & flags[k].end_ok;
		end
	end

	always_comb begin
		pos_inc   = (pos_q == POS_MAX) ? POS_MAX : pos_q + PW'(1);
		start_hit = !start_q && (pos_q >= PW'(sl_eff - 4'd1)) && start_all;
		start_new = start_q || start_hit;
		seg_new   = start_hit ? pos_inc : seg_q;
		end_hit   = (el_eff != 4'd0) && !end_q && (pos_q >= PW'(el_eff - 4'd1)) && end_all;
		end_new   = end_q || end_hit;
		end_pos   = pos_q - PW'(el_eff - 4'd1);
		err3_new  = end_hit ? (!start_new || (end_pos <= seg_new)) : err3_q;
		gap       = pos_q - seg_new;
		emit      = start_new && !end_q && (pos_q >= seg_new) && (gap >= PW'(el_eff));

		if (!start_new) begin
			oc = dse_pkg::OUTCOME_NO_START;
		end else if ((el_eff != 4'd0) && !end_new) begin
			oc = dse_pkg::OUTCOME_NO_END;
		end else if (end_new && err3_new) begin
			oc = dse_pkg::OUTCOME_ORDER;
		end else begin
			oc = dse_pkg::OUTCOME_OK;
		end

		result.out_byte    = emit ? tap[el_eff[TAPW-1:0]] : 8'd0;
		result.byte_valid  = emit;
		result.stream_done = last;
		result.outcome     = last ? oc : dse_pkg::OUTCOME_OK;
		push               = accept && (emit || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_len_q <= 4'd1;
			start_pat_q <= '0;
			end_len_q   <= 4'd0;
			end_pat_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dse_pkg::CFG_START_LENGTH:  start_len_q <= cfg_data[3:0];
				dse_pkg::CFG_START_PATTERN: start_pat_q <= cfg_data;
				dse_pkg::CFG_END_LENGTH:    end_len_q   <= cfg_data[3:0];
				dse_pkg::CFG_END_PATTERN:   end_pat_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			seg_q   <= '0;
			start_q <= 1'b0;
			end_q   <= 1'b0;
			err3_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				pos_q   <= '0;
				seg_q   <= '0;
				start_q <= 1'b0;
				end_q   <= 1'b0;
				err3_q  <= 1'b0;
			end else begin
				pos_q   <= pos_inc;
				seg_q   <= seg_new;
				start_q <= start_new;
				end_q   <= end_new;
				err3_q  <= err3_new;
			end
		end
	end

	dse_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(result),
		.space    (space),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

	`DSE_ASSERT_ALWAYS(a_segment_not_ahead, start_q |-> (seg_q <= pos_q))
	`DSE_ASSERT_ALWAYS(a_early_end_flagged, (end_q && !start_q) |-> err3_q)
	`DSE_ASSERT(a_last_clears, (accept && last) |=> ((pos_q == '0) && !start_q && !end_q))

endmodule
`default_nettype wire

>>> tb/delimited_segment_extractor_test.sv
// Self-checking testbench for the delimited segment extractor: directed and random byte streams
// under changing token settings, every result compared with a behavioural model held here.
// Depends on dse_pkg and the delimited_segment_extractor top level.
module delimited_segment_extractor_test;

	localparam int POSITION_WIDTH = 32;
	localparam int TOKEN_MAX      = 8;
	localparam int SETTLE_CYCLES  = 4;
	localparam int RANDOM_BYTES   = 1100;
	localparam logic [POSITION_WIDTH-1:0] POSITION_MAX = '1;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	dse_pkg::cfg_index_t       cfg_index = dse_pkg::CFG_START_LENGTH;
	logic [dse_pkg::CFG_W-1:0] cfg_data  = '0;
	logic                      req_valid = 1'b0;
	logic                      req_ready;
	dse_pkg::req_t             req_data  = '0;
	logic                      res_valid;
	logic                      res_ready = 1'b0;
	dse_pkg::res_t             res_data;

	// Register copies, at their reset values.
	logic [3:0]        start_len_reg = 4'd1;
	logic [3:0]        end_len_reg   = 4'd0;
	dse_pkg::pattern_t start_pat_reg = '0;
	dse_pkg::pattern_t end_pat_reg   = '0;

	// Stream state of the model.
	logic [7:0]                recent [0:TOKEN_MAX];
	logic [POSITION_WIDTH-1:0] position;
	logic [POSITION_WIDTH-1:0] seg_begin;
	logic                      start_found;
	logic                      end_found;
	logic                      order_fault;

	dse_pkg::res_t predicted_outputs [$];
	dse_pkg::req_t bytes_to_send [$];
	int            in_flight        = 0;
	int unsigned   req_idle_left    = 0;
	int unsigned   res_stall_left   = 0;
	bit            req_taken        = 1'b0;
	bit            calm             = 1'b0;
	bit            tight            = 1'b0;
	logic [7:0]    alphabet [0:1];
	int unsigned   failures         = 0;
	int unsigned   results_checked  = 0;
	int unsigned   bytes_queued     = 0;
	int unsigned   streams_sent     = 0;
	int unsigned   settings_applied = 0;

	delimited_segment_extractor #(
		.TOKEN_MAX(TOKEN_MAX),
		.POSITION_WIDTH(POSITION_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned start_span(logic [3:0] len);
		if (len == 4'd0)
			return 1;
		return (len > 4'(TOKEN_MAX)) ? TOKEN_MAX : 32'(len);
	endfunction

	function automatic int unsigned end_span(logic [3:0] len);
		return (len > 4'(TOKEN_MAX)) ? TOKEN_MAX : 32'(len);
	endfunction

	function automatic void clear_stream_state();
		foreach (recent[i])
			recent[i] = '0;
		position    = '0;
		seg_begin   = '0;
		start_found = 1'b0;
		end_found   = 1'b0;
		order_fault = 1'b0;
	endfunction

	function automatic bit window_holds(dse_pkg::pattern_t pat, int unsigned n);
		for (int i = 0; i < n; i++)
			if (recent[n - 1 - i] != pat[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void advance_extractor(dse_pkg::req_t r);
		int unsigned               sl;
		int unsigned               el;
		logic [POSITION_WIDTH-1:0] p;
		logic [POSITION_WIDTH-1:0] end_first;
		logic                      ended_before;
		dse_pkg::res_t             produced;
		sl           = start_span(start_len_reg);
		el           = end_span(end_len_reg);
		p            = position;
		ended_before = end_found;
		produced     = '0;
		for (int i = TOKEN_MAX; i > 0; i--)
			recent[i] = recent[i - 1];
		recent[0] = r.data_byte;
		// The start token is tested first, so one byte may complete both tokens.
		if (!start_found && p >= sl - 1 && window_holds(start_pat_reg, sl)) begin
			start_found = 1'b1;
			seg_begin   = (p < POSITION_MAX) ? p + 1 : POSITION_MAX;
		end
		if (el > 0 && !end_found && p >= el - 1 && window_holds(end_pat_reg, el)) begin
			end_first   = p - (el - 1);
			end_found   = 1'b1;
			order_fault = !start_found || end_first <= seg_begin;
		end
		if (start_found && !ended_before && p >= seg_begin && p - seg_begin >= el) begin
			produced.byte_valid = 1'b1;
			produced.out_byte   = recent[el];
		end
		position = (p < POSITION_MAX) ? p + 1 : POSITION_MAX;
		if (r.last_byte) begin
			produced.stream_done = 1'b1;
			if (!start_found)
				produced.outcome = dse_pkg::OUTCOME_NO_START;
			else if (el > 0 && !end_found)
				produced.outcome = dse_pkg::OUTCOME_NO_END;
			else if (end_found && order_fault)
				produced.outcome = dse_pkg::OUTCOME_ORDER;
			else
				produced.outcome = dse_pkg::OUTCOME_OK;
			clear_stream_state();
		end
		if (produced.byte_valid || produced.stream_done)
			predicted_outputs.push_back(produced);
	endfunction

	function automatic int unsigned idle_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] fill_byte(bit strict);
		if (tight && (strict || $urandom_range(0, 3) != 0))
			return alphabet[$urandom_range(0, 1)];
		return 8'($urandom_range(0, 255));
	endfunction

	always @(posedge clk) begin : sample_outputs
		dse_pkg::res_t want;
		req_taken <= req_valid && req_ready;
		if (arst_n && res_valid && res_ready) begin
			if (predicted_outputs.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("Unexpected result: byte %h valid %b done %b outcome %0d",
						res_data.out_byte, res_data.byte_valid, res_data.stream_done,
						res_data.outcome);
			end else begin
				want = predicted_outputs.pop_front();
				results_checked++;
				if (res_data.out_byte !== want.out_byte || res_data.byte_valid !== want.byte_valid
						|| res_data.stream_done !== want.stream_done
						|| res_data.outcome !== want.outcome) begin
					failures++;
					if (failures <= 10)
						$display("Mismatch: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
							want.out_byte, want.byte_valid, want.stream_done, want.outcome,
							res_data.out_byte, res_data.byte_valid, res_data.stream_done,
							res_data.outcome);
				end
			end
		end
		if (arst_n && req_valid && req_ready) begin
			in_flight--;
			advance_extractor(req_data);
		end
	end

	always @(negedge clk) begin : drive_requests
		if (!req_valid || req_taken) begin
			if (req_idle_left > 0) begin
				req_valid     <= 1'b0;
				req_idle_left <= req_idle_left - 1;
			end else if (bytes_to_send.size() > 0) begin
				req_data      <= bytes_to_send.pop_front();
				req_valid     <= 1'b1;
				req_idle_left <= idle_length();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_result_ready
		if (res_stall_left > 0) begin
			res_ready      <= 1'b0;
			res_stall_left <= res_stall_left - 1;
		end else begin
			res_ready      <= 1'b1;
			res_stall_left <= idle_length();
		end
	end

	task automatic write_register(dse_pkg::cfg_index_t idx, logic [dse_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dse_pkg::CFG_START_LENGTH: start_len_reg = value[3:0];
			dse_pkg::CFG_START_PATTERN: start_pat_reg = value;
			dse_pkg::CFG_END_LENGTH: end_len_reg = value[3:0];
			dse_pkg::CFG_END_PATTERN: end_pat_reg = value;
			default: ;
		endcase
	endtask

	task automatic configure(logic [3:0] s_len, dse_pkg::pattern_t s_pat,
			logic [3:0] e_len, dse_pkg::pattern_t e_pat);
		write_register(dse_pkg::CFG_START_LENGTH, dse_pkg::CFG_W'(s_len));
		write_register(dse_pkg::CFG_START_PATTERN, s_pat);
		write_register(dse_pkg::CFG_END_LENGTH, dse_pkg::CFG_W'(e_len));
		write_register(dse_pkg::CFG_END_PATTERN, e_pat);
		settings_applied++;
	endtask

	task automatic send_stream(input logic [7:0] s[$]);
		dse_pkg::req_t item;
		foreach (s[i]) begin
			item.data_byte = s[i];
			item.last_byte = (i == s.size() - 1);
			bytes_to_send.push_back(item);
			in_flight++;
			bytes_queued++;
		end
		streams_sent++;
	endtask

	task automatic add_token(ref logic [7:0] s[$], input dse_pkg::pattern_t pat,
			input int unsigned n);
		for (int i = 0; i < n; i++)
			s.push_back(pat[i]);
	endtask

	task automatic add_filler(ref logic [7:0] s[$], input int unsigned n);
		repeat (n)
			s.push_back(fill_byte(1'b0));
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (in_flight != 0 || predicted_outputs.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : run_phases
		logic [7:0]        stream [$];
		int unsigned       phase;
		int unsigned       phase_start;
		int unsigned       kind;
		int unsigned       mode;
		logic [3:0]        s_len;
		logic [3:0]        e_len;
		dse_pkg::pattern_t s_pat;
		dse_pkg::pattern_t e_pat;
		clear_stream_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single-byte start token with a start length below range, no end token.
		configure(4'd0, '1, 4'd0, '0);
		stream = {8'h00, 8'hFF, 8'h12, 8'hFF};
		send_stream(stream);
		stream = {8'h00};
		send_stream(stream);
		wait_drained();

		// One byte closes both tokens; an end token with no start token.
		configure(4'd2, 64'h0201, 4'd1, 64'h02);
		stream = {8'h01, 8'h02, 8'h05};
		send_stream(stream);
		stream = {8'h02};
		send_stream(stream);
		wait_drained();

		// Both lengths above range, so full-width tokens; the end token never comes.
		configure(4'd15, '1, 4'd15, '0);
		stream.delete();
		repeat (8) stream.push_back(8'hFF);
		stream.push_back(8'h5A);
		send_stream(stream);
		wait_drained();

		phase = 0;
		phase_start = bytes_queued;
		while (bytes_queued - phase_start < RANDOM_BYTES) begin
			calm = (phase % 4 == 3);
			mode = $urandom_range(0, 3);
			tight = (mode != 1);
			alphabet[0] = (mode == 3) ? 8'h00 : 8'($urandom_range(0, 255));
			alphabet[1] = (mode == 3) ? 8'hFF : 8'($urandom_range(0, 255));
			if (phase == 0) begin
				s_len = 4'd8;
				e_len = 4'd8;
			end else if (phase == 1) begin
				s_len = 4'd1;
				e_len = 4'd0;
			end else begin
				s_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 8));
				e_len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, 8));
			end
			for (int i = 0; i < TOKEN_MAX; i++) begin
				s_pat[i] = fill_byte(1'b1);
				e_pat[i] = fill_byte(1'b1);
			end
			configure(s_len, s_pat, e_len, e_pat);
			for (int n = 0; n < 90; n += stream.size()) begin
				stream.delete();
				kind = $urandom_range(0, 19);
				add_filler(stream, $urandom_range(0, 10));
				if (kind < 13) begin
					add_token(stream, start_pat_reg, start_span(start_len_reg));
					add_filler(stream, $urandom_range(0, 16));
					add_token(stream, end_pat_reg, end_span(end_len_reg));
					add_filler(stream, $urandom_range(0, 4));
				end else if (kind < 15) begin
					add_token(stream, end_pat_reg, end_span(end_len_reg));
					add_filler(stream, $urandom_range(0, 4));
					add_token(stream, start_pat_reg, start_span(start_len_reg));
					add_filler(stream, $urandom_range(0, 6));
				end else if (kind < 17) begin
					add_token(stream, start_pat_reg, start_span(start_len_reg));
					add_filler(stream, $urandom_range(0, 12));
				end else if (kind < 18) begin
					add_token(stream, start_pat_reg, start_span(start_len_reg));
					add_token(stream, end_pat_reg, end_span(end_len_reg));
					add_filler(stream, $urandom_range(0, 2));
				end else begin
					add_filler(stream, $urandom_range(0, 20));
				end
				if (stream.size() == 0)
					add_filler(stream, 1);
				send_stream(stream);
			end
			wait_drained();
			phase++;
		end

		$display("Checked %0d results from %0d bytes in %0d streams over %0d token settings.",
			results_checked, bytes_queued, streams_sent, settings_applied);
		$display("Mismatches found: %0d.", failures);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Run timed out with %0d requests outstanding.", in_flight);
		$display("TB_ERROR");
		$finish;
	end

endmodule

>>> delimited_segment_extractor.f
+incdir+sv
sv/dse_pkg.sv
sv/dse_cell.sv
sv/dse_outbuf.sv
sv/delimited_segment_extractor.sv
tb/delimited_segment_extractor_test.sv
